// ===== design/quaternion_to_rotation_matrix_defines.svh =====
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH
`define QUATERNION_TO_ROTATION_MATRIX_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define QRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define QRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/qrm_pkg.sv =====
package qrm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int IW = 16;
  localparam int SW = 2 * IW + 1;
  localparam int PW = 2 * IW + 1;
  localparam int MW = 2 * IW;
  localparam int QB = FRAC_BITS + 2;
  localparam int NW = MW + FRAC_BITS + 2;
  localparam int RW = SW + 1;
  localparam int VW = (FRAC_BITS + 4 > IW + 1) ? FRAC_BITS + 4 : IW + 1;

  typedef logic signed [IW-1:0] elem_t;
  typedef logic signed [2*IW-1:0] prod_t;
  typedef logic signed [PW-1:0] psum_t;
  typedef logic [SW-1:0] ssum_t;

  typedef struct packed {
    logic neg;
    logic diag;
    logic zero;
  } lane_ctl_t;

endpackage

// ===== design/qrm_if.sv =====
interface qrm_in_if;
  import qrm_pkg::*;
  logic valid;
  logic ready;
  elem_t q_w;
  elem_t q_x;
  elem_t q_y;
  elem_t q_z;
  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

interface qrm_out_if;
  import qrm_pkg::*;
  logic valid;
  logic ready;
  elem_t m00;
  elem_t m01;
  elem_t m02;
  elem_t m10;
  elem_t m11;
  elem_t m12;
  elem_t m20;
  elem_t m21;
  elem_t m22;
  logic zero_norm;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                output ready);
endinterface

// ===== design/quaternion_to_rotation_matrix.sv =====
// Converts a Q2.14 quaternion to its normalized 3x3 rotation matrix in Q2.14, one word per
// cycle while no finished word waits at the output: two stages form the products and sums,
// then each of the nine elements goes through its own pipelined restoring divider that
// retires one quotient bit per stage, and a last stage applies sign, the diagonal offset and
// saturation. A zero quaternion gives zero off the diagonal, -1.0 on it, and sets zero_norm.
// The whole pipeline stalls only while a finished word waits at the output.
`include "quaternion_to_rotation_matrix_defines.svh"

module quaternion_to_rotation_matrix (
  input logic       clk,
  input logic       rst,
  qrm_in_if.sink    quat,
  qrm_out_if.source mat
);
  import qrm_pkg::*;

  localparam int LAT = QB + 4;
  localparam logic [8:0] DIAG_MASK = 9'b100010001;

  logic           adv;
  logic [LAT-1:0] vld;
  logic [LAT-1:0] zp;

  prod_t pww, pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
  psum_t pe [9];
  ssum_t ssum;
  elem_t me [9];

  assign adv        = !mat.valid || mat.ready;
  assign quat.ready = adv;
  assign mat.valid  = vld[LAT-1];
  assign mat.zero_norm = zp[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], quat.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zp  <= {zp[LAT-2:0], (quat.q_w == '0) && (quat.q_x == '0) &&
                           (quat.q_y == '0) && (quat.q_z == '0)};
      pww <= quat.q_w * quat.q_w;
      pxx <= quat.q_x * quat.q_x;
      pyy <= quat.q_y * quat.q_y;
      pzz <= quat.q_z * quat.q_z;
      pxy <= quat.q_x * quat.q_y;
      pxz <= quat.q_x * quat.q_z;
      pyz <= quat.q_y * quat.q_z;
      pxw <= quat.q_x * quat.q_w;
      pyw <= quat.q_y * quat.q_w;
      pzw <= quat.q_z * quat.q_w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ssum  <= SW'($unsigned(pww)) + SW'($unsigned(pxx)) + SW'($unsigned(pyy))
             + SW'($unsigned(pzz));
      pe[0] <= PW'(pxx) + PW'(pww);
      pe[1] <= PW'(pxy) - PW'(pzw);
      pe[2] <= PW'(pxz) + PW'(pyw);
      pe[3] <= PW'(pxy) + PW'(pzw);
      pe[4] <= PW'(pyy) + PW'(pww);
      pe[5] <= PW'(pyz) - PW'(pxw);
      pe[6] <= PW'(pxz) - PW'(pyw);
      pe[7] <= PW'(pyz) + PW'(pxw);
      pe[8] <= PW'(pzz) + PW'(pww);
    end
  end

  for (genvar i = 0; i < 9; i++) begin : g_lane
    qrm_div u_div (
      .clk  (clk),
      .en   (adv),
      .p    (pe[i]),
      .s    (ssum),
      .diag (DIAG_MASK[i]),
      .m    (me[i])
    );
  end

  assign mat.m00 = me[0];
  assign mat.m01 = me[1];
  assign mat.m02 = me[2];
  assign mat.m10 = me[3];
  assign mat.m11 = me[4];
  assign mat.m12 = me[5];
  assign mat.m20 = me[6];
  assign mat.m21 = me[7];
  assign mat.m22 = me[8];

  `QRM_ASSERT_NOW(a_zero_offdiag, mat.valid && mat.zero_norm, (mat.m01 == '0) && (mat.m12 == '0) && (mat.m20 == '0), "zero quaternion gave a nonzero off-diagonal element")
  `QRM_ASSERT_NOW(a_stall_cause, !quat.ready, mat.valid, "input stalled with no word waiting at the output")
  `QRM_ASSERT_NEXT(a_hold_zero, mat.valid && !mat.ready, mat.zero_norm == $past(mat.zero_norm), "zero flag changed while the output was stalled")

endmodule

// ===== design/qrm_div.sv =====
module qrm_div (
  input  logic                  clk,
  input  logic                  en,
  input  qrm_pkg::psum_t        p,
  input  qrm_pkg::ssum_t        s,
  input  logic                  diag,
  output qrm_pkg::elem_t        m
);
  import qrm_pkg::*;

  localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] MAX_V = VW'(32'sd32767);
  localparam logic signed [VW-1:0] MIN_V = VW'(-32'sd32768);

  logic            neg;
  logic [MW-1:0]   mag;
  logic [NW-1:0]   dnum;

  lane_ctl_t       ctl [QB+1];
  logic [RW-1:0]   rem [QB+1];
  logic [QB-1:0]   dd  [QB+1];
  logic [QB-1:0]   quo [QB+1];
  ssum_t           sv  [QB+1];

  logic signed [VW-1:0] qv;
  logic signed [VW-1:0] val;
  logic signed [VW-1:0] sat;

  assign neg  = p < 0;
  assign mag  = neg ? MW'(-p) : MW'(p);
  assign dnum = NW'({mag, {(FRAC_BITS + 1){1'b0}}}) + NW'(s >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(dnum[NW-1:QB]);
      dd[0]  <= dnum[QB-1:0];
      quo[0] <= '0;
      sv[0]  <= s;
      ctl[0] <= '{neg: neg, diag: diag, zero: (s == '0)};
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    assign t  = {rem[k-1][RW-2:0], dd[k-1][QB-1]};
    assign ge = t >= RW'(sv[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? t - RW'(sv[k-1]) : t;
        dd[k]  <= dd[k-1] << 1;
        quo[k] <= {quo[k-1][QB-2:0], ge};
        sv[k]  <= sv[k-1];
        ctl[k] <= ctl[k-1];
      end
    end
  end

  always_comb begin
    qv  = VW'(quo[QB]);
    val = ctl[QB].zero ? '0 : (ctl[QB].neg ? -qv : qv);
    if (ctl[QB].diag) begin
      val = val - ONE_V;
    end
    if (val > MAX_V) begin
      sat = MAX_V;
    end else if (val < MIN_V) begin
      sat = MIN_V;
    end else begin
      sat = val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m <= IW'(sat);
    end
  end

endmodule
